// File: src/assert_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Checks that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/x86enc_pkg.sv
package x86enc_pkg;

    // Code buffer size and the width of the write position.
    localparam int BUFFER_BYTES = 65536;
    localparam int POS_W        = $clog2(BUFFER_BYTES);
    localparam int ADDR_W       = 16;

    // Longest encoding, in bytes.
    localparam int MAX_BYTES = 10;
    localparam int CNT_BYTES_W = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_BYTES);

    // Depth of the queue between the front and the back.
    localparam int FIFO_DEPTH = 2;

    // Instruction forms.
    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_RET       = 5'd1;
    localparam logic [4:0] OP_LEAVE     = 5'd2;
    localparam logic [4:0] OP_PUSH      = 5'd3;
    localparam logic [4:0] OP_POP       = 5'd4;
    localparam logic [4:0] OP_CALL      = 5'd5;
    localparam logic [4:0] OP_MOV_IMM   = 5'd6;
    localparam logic [4:0] OP_MOV_RR    = 5'd7;
    localparam logic [4:0] OP_MOV_ST    = 5'd8;
    localparam logic [4:0] OP_MOV_STD   = 5'd9;
    localparam logic [4:0] OP_MOV_LD    = 5'd10;
    localparam logic [4:0] OP_MOV_LDD   = 5'd11;
    localparam logic [4:0] OP_LEA       = 5'd12;
    localparam logic [4:0] OP_INC       = 5'd13;
    localparam logic [4:0] OP_ADD_IMM   = 5'd14;
    localparam logic [4:0] OP_ADD_RR    = 5'd15;
    localparam logic [4:0] OP_ADDSD     = 5'd16;
    localparam logic [4:0] OP_DEC       = 5'd17;
    localparam logic [4:0] OP_SUB_IMM   = 5'd18;
    localparam logic [4:0] OP_SUB_RR    = 5'd19;
    localparam logic [4:0] OP_SUBSD     = 5'd20;
    localparam logic [4:0] OP_XOR       = 5'd21;
    localparam logic [4:0] OP_CMP       = 5'd22;
    localparam logic [4:0] OP_TEST      = 5'd23;
    localparam logic [4:0] OP_JMP       = 5'd24;
    localparam logic [4:0] OP_JC        = 5'd25;
    localparam logic [4:0] OP_JNE       = 5'd26;
    localparam logic [4:0] OP_JNA       = 5'd27;
    localparam logic [4:0] OP_SETL      = 5'd28;

    // One classified instruction: its bytes, how many, and the error flag.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_BYTES_W-1:0]    count;
        logic                      err;
    } t_desc;

endpackage

// File: src/x86enc_front.sv
module x86enc_front (
    input  logic [4:0]             i_opcode,
    input  logic [4:0]             i_first_reg,
    input  logic [4:0]             i_second_reg,
    input  logic [7:0]             i_byte_operand,
    input  logic [63:0]            i_wide_immediate,
    output logic                   o_desc_valid,
    output x86enc_pkg::t_desc      o_desc
);
    import x86enc_pkg::*;

    localparam logic [7:0] REX_W   = 8'h48;
    localparam logic [7:0] MOD_IND = 8'h00;
    localparam logic [7:0] MOD_D8  = 8'h40;
    localparam logic [7:0] MOD_REG = 8'hC0;
    localparam logic [7:0] SIB_RSP = 8'h24;
    localparam logic [7:0] PFX_F2  = 8'hF2;
    localparam logic [4:0] RSP_NUM = 5'd4;

    // REX with only the B extension.
    function automatic logic [7:0] rex1(input logic [4:0] rm);
        rex1 = REX_W | {7'b0, rm[3]};
    endfunction

    // REX with the B and R extensions.
    function automatic logic [7:0] rex2(input logic [4:0] rm, input logic [4:0] rg);
        rex2 = REX_W | {5'b0, rg[3], 1'b0, rm[3]};
    endfunction

    // ModRM byte; mod is already in its top two bits.
    function automatic logic [7:0] mrm(input logic [7:0] md, input logic [4:0] rm,
                                       input logic [4:0] rg);
        mrm = md | {2'b0, rg[2:0], rm[2:0]};
    endfunction

    logic                      one;
    logic                      two;
    logic                      xmm;
    logic                      a_gpr;
    logic                      b_gpr;
    logic [4:0]                a;
    logic [4:0]                b;
    logic [7:0]                d8;
    logic [MAX_BYTES-1:0][7:0] bt;
    logic [CNT_BYTES_W-1:0]    n;

    assign a  = i_first_reg;
    assign b  = i_second_reg;
    assign d8 = i_byte_operand;
    assign a_gpr = !a[4];
    assign b_gpr = !b[4];

    // Register class that each form expects.
    always_comb begin
        one = 1'b0;
        two = 1'b0;
        xmm = 1'b0;
        case (i_opcode)
            OP_PUSH, OP_POP, OP_CALL, OP_MOV_IMM, OP_INC, OP_ADD_IMM, OP_DEC,
            OP_SUB_IMM, OP_SETL: begin
                one = 1'b1;
            end
            OP_ADDSD, OP_SUBSD: begin
                xmm = 1'b1;
            end
            OP_MOV_RR, OP_MOV_ST, OP_MOV_STD, OP_MOV_LD, OP_MOV_LDD, OP_LEA,
            OP_ADD_RR, OP_SUB_RR, OP_XOR, OP_CMP, OP_TEST: begin
                two = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Byte sequence of each form.
    always_comb begin
        bt = '0;
        n  = CNT_BYTES_W'(1);
        case (i_opcode)
            OP_NOP:   bt[0] = 8'h90;
            OP_RET:   bt[0] = 8'hC3;
            OP_LEAVE: bt[0] = 8'hC9;
            OP_PUSH: begin
                bt[0] = rex1(a);
                bt[1] = 8'h50 | {5'b0, a[2:0]};
                n = CNT_BYTES_W'(2);
            end
            OP_POP: begin
                bt[0] = rex1(a);
                bt[1] = 8'h58 | {5'b0, a[2:0]};
                n = CNT_BYTES_W'(2);
            end
            OP_CALL: begin
                bt[0] = rex1(a);
                bt[1] = 8'hFF;
                bt[2] = 8'hD0 | {5'b0, a[2:0]};
                n = CNT_BYTES_W'(3);
            end
            OP_MOV_IMM: begin
                bt[0] = rex1(a);
                bt[1] = 8'hB8 | {5'b0, a[2:0]};
                for (int i = 0; i < 8; i++) begin
                    bt[i+2] = i_wide_immediate[8*i +: 8];
                end
                n = CNT_BYTES_W'(10);
            end
            OP_MOV_RR, OP_ADD_RR, OP_SUB_RR, OP_XOR, OP_CMP, OP_TEST: begin
                bt[0] = rex2(a, b);
                case (i_opcode)
                    OP_MOV_RR: bt[1] = 8'h89;
                    OP_ADD_RR: bt[1] = 8'h01;
                    OP_SUB_RR: bt[1] = 8'h29;
                    OP_XOR:    bt[1] = 8'h31;
                    OP_CMP:    bt[1] = 8'h39;
                    default:   bt[1] = 8'h85;
                endcase
                bt[2] = mrm(MOD_REG, a, b);
                n = CNT_BYTES_W'(3);
            end
            OP_MOV_ST: begin
                bt[0] = rex2(a, b);
                bt[1] = 8'h89;
                bt[2] = mrm(MOD_IND, a, b);
                if (a == RSP_NUM) begin
                    bt[3] = SIB_RSP;
                    n = CNT_BYTES_W'(4);
                end else begin
                    n = CNT_BYTES_W'(3);
                end
            end
            OP_MOV_STD: begin
                bt[0] = rex2(a, b);
                bt[1] = 8'h89;
                bt[2] = mrm(MOD_D8, a, b);
                if (a == RSP_NUM) begin
                    bt[3] = SIB_RSP;
                    bt[4] = d8;
                    n = CNT_BYTES_W'(5);
                end else begin
                    bt[3] = d8;
                    n = CNT_BYTES_W'(4);
                end
            end
            OP_MOV_LD: begin
                bt[0] = rex2(b, a);
                bt[1] = 8'h8B;
                bt[2] = mrm(MOD_IND, b, a);
                if (b == RSP_NUM) begin
                    bt[3] = SIB_RSP;
                    n = CNT_BYTES_W'(4);
                end else begin
                    n = CNT_BYTES_W'(3);
                end
            end
            OP_MOV_LDD, OP_LEA: begin
                bt[0] = rex2(b, a);
                bt[1] = (i_opcode == OP_MOV_LDD) ? 8'h8B : 8'h8D;
                bt[2] = mrm(MOD_D8, b, a);
                if (b == RSP_NUM) begin
                    bt[3] = SIB_RSP;
                    bt[4] = d8;
                    n = CNT_BYTES_W'(5);
                end else begin
                    bt[3] = d8;
                    n = CNT_BYTES_W'(4);
                end
            end
            OP_INC, OP_DEC: begin
                bt[0] = rex1(a);
                bt[1] = 8'hFF;
                bt[2] = ((i_opcode == OP_INC) ? 8'hC0 : 8'hC8) | {5'b0, a[2:0]};
                n = CNT_BYTES_W'(3);
            end
            OP_ADD_IMM, OP_SUB_IMM: begin
                bt[0] = rex1(a);
                bt[1] = 8'h83;
                bt[2] = ((i_opcode == OP_ADD_IMM) ? 8'hC0 : 8'hE8) | {5'b0, a[2:0]};
                bt[3] = d8;
                n = CNT_BYTES_W'(4);
            end
            OP_ADDSD, OP_SUBSD: begin
                // The F2 prefix precedes REX.
                bt[0] = PFX_F2;
                bt[1] = rex2(b, a);
                bt[2] = 8'h0F;
                bt[3] = (i_opcode == OP_ADDSD) ? 8'h58 : 8'h5C;
                bt[4] = mrm(MOD_REG, b, a);
                n = CNT_BYTES_W'(5);
            end
            OP_JMP, OP_JC, OP_JNE, OP_JNA: begin
                case (i_opcode)
                    OP_JMP:  bt[0] = 8'hEB;
                    OP_JC:   bt[0] = 8'h72;
                    OP_JNE:  bt[0] = 8'h75;
                    default: bt[0] = 8'h76;
                endcase
                bt[1] = d8;
                n = CNT_BYTES_W'(2);
            end
            default: begin
                // Set on less, and the unused codes that never reach the queue.
                bt[0] = rex1(a);
                bt[1] = 8'h0F;
                bt[2] = 8'h9C;
                bt[3] = 8'hC0 | {5'b0, a[2:0]};
                n = CNT_BYTES_W'(4);
            end
        endcase
    end

    // Unused opcodes produce nothing and are dropped here.
    assign o_desc_valid = (i_opcode <= OP_SETL);
    assign o_desc.err   = (one && !a_gpr) || (two && (!a_gpr || !b_gpr)) ||
                          (xmm && (a_gpr || b_gpr));
    assign o_desc.bytes = bt;
    assign o_desc.count = o_desc.err ? CNT_BYTES_W'(1) : n;

endmodule

// File: src/x86enc_fifo.sv
`include "assert_macros.svh"

module x86enc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  x86enc_pkg::t_desc  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output x86enc_pkg::t_desc  o_data
);
    import x86enc_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_desc             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Pointer that steps around the ring.
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= ptr_next(r_wr);
            end
            if (rd_en) begin
                r_rd <= ptr_next(r_rd);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_HOLDS(a_count_in_range, i_clk, i_rst_n, r_count <= CNT_W'(FIFO_DEPTH))
    `ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, o_full && !i_pop, o_full)
    `ASSERT_NEXT(a_empty_holds, i_clk, i_rst_n, o_empty && !i_push, o_empty)

endmodule

// File: src/x86enc_back.sv
`include "assert_macros.svh"

module x86enc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_empty,
    input  x86enc_pkg::t_desc             i_head,
    output logic                          o_head_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [7:0]                    o_code_byte,
    output logic [x86enc_pkg::ADDR_W-1:0] o_byte_address,
    output logic                          o_byte_valid,
    output logic                          o_status,
    output logic                          o_last
);
    import x86enc_pkg::*;

    logic [IDX_W-1:0]  r_idx;
    logic [POS_W-1:0]  r_pos;
    logic              r_ov;
    logic [7:0]        r_code;
    logic [ADDR_W-1:0] r_addr;
    logic              r_bvalid;
    logic              r_status;
    logic              r_last;
    logic              load;
    logic              is_last;
    logic [POS_W-1:0]  n_pos;

    // A new byte moves into the output register when it is free or being taken.
    assign load    = !i_head_empty && (!r_ov || i_pop);
    assign is_last = i_head.err ||
                     (CNT_BYTES_W'(r_idx) == i_head.count - 1'b1);
    assign o_head_pop = load && is_last;
    assign n_pos   = (r_pos == POS_W'(BUFFER_BYTES - 1)) ? '0 : r_pos + 1'b1;

    // Byte sequencer and write position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_pos <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (load) begin
                r_ov  <= 1'b1;
                r_idx <= is_last ? '0 : r_idx + 1'b1;
                if (!i_head.err) begin
                    r_pos <= n_pos;
                end
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code   <= i_head.err ? 8'h00 : i_head.bytes[r_idx];
            r_addr   <= ADDR_W'(r_pos);
            r_bvalid <= !i_head.err;
            r_status <= i_head.err;
            r_last   <= is_last;
        end
    end

    assign o_empty        = !r_ov;
    assign o_code_byte    = r_code;
    assign o_byte_address = r_addr;
    assign o_byte_valid   = r_bvalid;
    assign o_status       = r_status;
    assign o_last         = r_last;

    `ASSERT_HOLDS(a_err_result_shape, i_clk, i_rst_n,
        !(r_ov && r_status) || (r_last && !r_bvalid))
    `ASSERT_HOLDS(a_idx_in_range, i_clk, i_rst_n, r_idx < IDX_W'(MAX_BYTES))
    `ASSERT_NEXT(a_pos_steps, i_clk, i_rst_n,
        load && !i_head.err && (r_pos != POS_W'(BUFFER_BYTES - 1)),
        r_pos == $past(r_pos) + 1'b1)

endmodule

// File: src/x86_64_instruction_byte_encoder_top.sv
// x86-64 instruction byte encoder. Each request names an instruction form, up to
// two registers (0-15 general, 16-31 XMM), a byte operand and a 64-bit immediate;
// the block returns the instruction's machine bytes, one result per byte, each with
// its code buffer address, and o_last on the final byte. A register of the wrong
// class gives a single status result with no byte, and opcodes above 28 give no
// result at all. The write position wraps at the end of the buffer. Requests are
// classified in a front stage and queued two deep; the back sequencer emits one
// byte per cycle while the consumer pops, so an instruction of n bytes (1 to 10)
// gives n results, and requests are taken back to back while the queue has room.
module x86_64_instruction_byte_encoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [4:0]                    i_opcode,
    input  logic [4:0]                    i_first_reg,
    input  logic [4:0]                    i_second_reg,
    input  logic [7:0]                    i_byte_operand,
    input  logic [63:0]                   i_wide_immediate,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_code_byte,
    output logic [x86enc_pkg::ADDR_W-1:0] o_byte_address,
    output logic                          o_byte_valid,
    output logic                          o_status,
    output logic                          o_last
);
    import x86enc_pkg::*;

    logic  desc_valid;
    t_desc desc;
    t_desc head;
    logic  head_empty;
    logic  head_pop;

    // Classify each request into its byte sequence.
    x86enc_front u_front (
        .i_opcode         (i_opcode),
        .i_first_reg      (i_first_reg),
        .i_second_reg     (i_second_reg),
        .i_byte_operand   (i_byte_operand),
        .i_wide_immediate (i_wide_immediate),
        .o_desc_valid     (desc_valid),
        .o_desc           (desc)
    );

    // Queue between classification and emission.
    x86enc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && desc_valid),
        .i_data  (desc),
        .o_full  (full),
        .i_pop   (head_pop),
        .o_empty (head_empty),
        .o_data  (head)
    );

    // Emit bytes one per cycle into the output register while the consumer pops them.
    x86enc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_empty   (head_empty),
        .i_head         (head),
        .o_head_pop     (head_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_code_byte    (o_code_byte),
        .o_byte_address (o_byte_address),
        .o_byte_valid   (o_byte_valid),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule
